### hdl/leh_pkg.sv
// ----------------------------------------------------------------------------
// leh_pkg
// Shared sizes, command codes, cell control and payload types of the line
// editor with history.
// ----------------------------------------------------------------------------
package leh_pkg;

  localparam int LINE_CAPACITY    = 64;
  localparam int HISTORY_ENTRIES  = 8;
  localparam int HIST_ENTRY_BYTES = 64;

  localparam int PW  = $clog2(LINE_CAPACITY);
  localparam int SW  = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
  localparam int CW  = $clog2(HISTORY_ENTRIES + 1);
  localparam int ELW = $clog2(HIST_ENTRY_BYTES);
  localparam int AW  = $clog2(HISTORY_ENTRIES * HIST_ENTRY_BYTES);

  localparam logic [4:0] CMD_LEFT       = 5'd0;
  localparam logic [4:0] CMD_RIGHT      = 5'd1;
  localparam logic [4:0] CMD_WORD_LEFT  = 5'd2;
  localparam logic [4:0] CMD_WORD_RIGHT = 5'd3;
  localparam logic [4:0] CMD_HOME       = 5'd4;
  localparam logic [4:0] CMD_END        = 5'd5;
  localparam logic [4:0] CMD_SEL_LEFT   = 5'd6;
  localparam logic [4:0] CMD_SEL_RIGHT  = 5'd7;
  localparam logic [4:0] CMD_SEL_WLEFT  = 5'd8;
  localparam logic [4:0] CMD_SEL_WRIGHT = 5'd9;
  localparam logic [4:0] CMD_SEL_HOME   = 5'd10;
  localparam logic [4:0] CMD_SEL_END    = 5'd11;
  localparam logic [4:0] CMD_DEL_LEFT   = 5'd12;
  localparam logic [4:0] CMD_DEL_RIGHT  = 5'd13;
  localparam logic [4:0] CMD_DEL_WORD   = 5'd14;
  localparam logic [4:0] CMD_PREV       = 5'd15;
  localparam logic [4:0] CMD_NEXT       = 5'd16;
  localparam logic [4:0] CMD_INSERT     = 5'd17;
  localparam logic [4:0] CMD_COMMIT     = 5'd18;

  // cell operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_INS   = 2'd1;
  localparam logic [1:0] OP_DEL   = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [PW-1:0] pos;
    logic [7:0]    data;
  } cell_ctrl_t;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] char_byte;
  } command_t;

  typedef struct packed {
    logic       is_line_byte;
    logic [7:0] line_byte;
    logic       last;
    logic [5:0] line_length;
    logic [5:0] cursor_pos;
    logic       select_on;
    logic [5:0] anchor_pos;
  } result_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
  endfunction

  function automatic logic is_blank_byte(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

endpackage

### hdl/leh_cell.sv
// ----------------------------------------------------------------------------
// leh_cell
// One byte of the line; opens a gap, closes a gap or takes a new byte.
// ----------------------------------------------------------------------------
module leh_cell (
  input  logic                  clk,
  input  leh_pkg::cell_ctrl_t   ctrl,
  input  logic [leh_pkg::PW-1:0] idx,
  input  logic [7:0]            left_byte,
  input  logic [7:0]            right_byte,
  output logic [7:0]            data,
  output logic                  word_c,
  output logic                  blank_c
);
  import leh_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INS: begin
        if (idx > ctrl.pos) begin
          data <= left_byte;
        end else if (idx == ctrl.pos) begin
          data <= ctrl.data;
        end
      end
      OP_DEL: begin
        if (idx >= ctrl.pos) begin
          data <= right_byte;
        end
      end
      OP_WRITE: begin
        if (idx == ctrl.pos) begin
          data <= ctrl.data;
        end
      end
      default: begin
      end
    endcase
  end

  assign word_c  = is_word_byte(data);
  assign blank_c = is_blank_byte(data);

endmodule

### hdl/line_editor_with_history_unit.sv
// ----------------------------------------------------------------------------
// line_editor_with_history_unit
// Single-line editor with cursor, selection and a ring of committed lines.
// ----------------------------------------------------------------------------
// The line sits in a row of byte cells that shift together, one position per
// clock. A command is taken when start is high and busy low; each result is
// shown for one cycle with strobe and cannot be held off. A plain move or a
// history step with nothing to do passes only through the execute and finish
// states; a word scan walks the cursor one byte a cycle; a delete removes one
// byte a cycle; an insert first cuts any selection; recalling a history entry
// reads the history memory one byte a cycle. A commit puts out one line byte
// a cycle while, with history on, it copies the line into the history memory.
module line_editor_with_history_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  leh_pkg::command_t command,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              strobe,
  output leh_pkg::result_t  result
);
  import leh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CUT  = 3'd3;
  localparam logic [2:0] ST_INS  = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam int SUMW = CW + 1;

  logic [2:0]    state;
  logic [4:0]    cmd_q;
  logic [7:0]    ch_q;
  logic [PW-1:0] len, cur, anc;
  logic          sel;
  logic [SW-1:0] oldest;
  logic [CW-1:0] count, bidx;
  logic          browsing, hen;

  logic [PW-1:0] p;
  logic          scan_right;
  logic [1:0]    scan_phase;
  logic          scan_cls;

  logic [PW-1:0] cut_lo, cut_cnt;

  logic [SW-1:0] ld_slot;
  logic [PW-1:0] ld_n, rd_idx, wr_idx;
  logic          wr_valid;

  logic          st_on;
  logic [SW-1:0] st_slot;
  logic [ELW-1:0] st_n;
  logic [PW-1:0] em_n, em_i;

  logic [ELW-1:0] entry_len [HISTORY_ENTRIES];
  logic [7:0]     mem [HISTORY_ENTRIES * HIST_ENTRY_BYTES];
  logic [7:0]     mem_q;
  logic [AW-1:0]  mem_addr;
  logic           mem_we;

  cell_ctrl_t          cctrl;
  logic [7:0]          cell_data [LINE_CAPACITY];
  logic [LINE_CAPACITY-1:0] word_v, blank_v;

  // combinational helpers
  logic          hs;
  logic [PW-1:0] lo, hi, step_l, step_r, mv_left, mv_right;
  logic [PW-1:0] sidx;
  logic          avail, c_word, c_blank, match;
  logic [CW-1:0] hist_idx, ring_off;
  logic [SUMW-1:0] ring_sum;
  logic [SW-1:0] ring_slot, oldest_inc;
  logic [PW-1:0] ld_n_c;
  logic [ELW-1:0] st_n_c;
  logic          next_ok, printable, em_last;

  // row of cells
  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [7:0] lb, rb;
    if (i == 0) begin : g_first
      assign lb = 8'h00;
    end else begin : g_mid
      assign lb = cell_data[i-1];
    end
    if (i == LINE_CAPACITY - 1) begin : g_lastc
      assign rb = 8'h00;
    end else begin : g_body
      assign rb = cell_data[i+1];
    end
    leh_cell u_cell (
      .clk        (clk),
      .ctrl       (cctrl),
      .idx        (PW'(i)),
      .left_byte  (lb),
      .right_byte (rb),
      .data       (cell_data[i]),
      .word_c     (word_v[i]),
      .blank_c    (blank_v[i])
    );
  end

  always_comb begin
    hs       = sel && (anc != cur);
    lo       = (anc < cur) ? anc : cur;
    hi       = (anc > cur) ? anc : cur;
    step_l   = (cur != '0) ? cur - PW'(1) : cur;
    step_r   = (cur < len) ? cur + PW'(1) : cur;
    mv_left  = hs ? lo : step_l;
    mv_right = hs ? hi : step_r;

    sidx    = scan_right ? p : p - PW'(1);
    avail   = scan_right ? (p < len) : (p != '0);
    c_word  = word_v[sidx];
    c_blank = blank_v[sidx];
    match   = scan_cls ? c_word : (!c_blank && !c_word);

    if (cmd_q == CMD_PREV) begin
      hist_idx = browsing ? ((bidx != '0) ? bidx - CW'(1) : bidx) : count - CW'(1);
    end else begin
      hist_idx = bidx + CW'(1);
    end
    next_ok  = (SUMW'(bidx) + SUMW'(1)) < SUMW'(count);
    ring_off = (cmd_q == CMD_COMMIT) ? count : hist_idx;
    ring_sum = SUMW'(oldest) + SUMW'(ring_off);
    if (ring_sum >= SUMW'(HISTORY_ENTRIES)) begin
      ring_sum = ring_sum - SUMW'(HISTORY_ENTRIES);
    end
    if (cmd_q == CMD_COMMIT && int'(count) >= HISTORY_ENTRIES) begin
      ring_slot = oldest;
    end else begin
      ring_slot = SW'(ring_sum);
    end
    oldest_inc = (int'(oldest) == HISTORY_ENTRIES - 1) ? '0 : oldest + SW'(1);

    ld_n_c = (int'(entry_len[ring_slot]) > LINE_CAPACITY - 1) ?
             PW'(LINE_CAPACITY - 1) : PW'(entry_len[ring_slot]);
    st_n_c = (int'(len) > HIST_ENTRY_BYTES - 1) ?
             ELW'(HIST_ENTRY_BYTES - 1) : ELW'(len);

    printable = (ch_q >= 8'h20) && (ch_q != 8'h7f);
    em_last   = (em_i == em_n - PW'(1));
  end

  // cell control
  always_comb begin
    cctrl.op   = OP_HOLD;
    cctrl.pos  = '0;
    cctrl.data = ch_q;
    case (state)
      ST_INS: begin
        if (int'(len) < LINE_CAPACITY - 1) begin
          cctrl.op  = OP_INS;
          cctrl.pos = cur;
        end
      end
      ST_CUT: begin
        if (cut_cnt != '0) begin
          cctrl.op  = OP_DEL;
          cctrl.pos = cut_lo;
        end
      end
      ST_LOAD: begin
        if (wr_valid) begin
          cctrl.op   = OP_WRITE;
          cctrl.pos  = wr_idx;
          cctrl.data = mem_q;
        end
      end
      ST_EMIT: begin
        cctrl.op = OP_DEL;
      end
      default: begin
      end
    endcase
  end

  // history memory, one port
  assign mem_we   = (state == ST_EMIT) && st_on && (int'(em_i) < int'(st_n));
  assign mem_addr = AW'(AW'((state == ST_EMIT) ? st_slot : ld_slot) *
                        AW'(HIST_ENTRY_BYTES)) +
                    ((state == ST_EMIT) ? AW'(em_i) : AW'(rd_idx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cell_data[0];
    end
    mem_q <= mem[mem_addr];
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      cur      <= '0;
      anc      <= '0;
      sel      <= 1'b0;
      oldest   <= '0;
      count    <= '0;
      bidx     <= '0;
      browsing <= 1'b0;
      hen      <= 1'b1;
      strobe   <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        hen <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= command.cmd;
            ch_q  <= command.char_byte;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_FIN;
          case (cmd_q)
            CMD_LEFT: begin
              cur <= mv_left;
              anc <= mv_left;
              sel <= 1'b0;
            end
            CMD_RIGHT: begin
              cur <= mv_right;
              anc <= mv_right;
              sel <= 1'b0;
            end
            CMD_WORD_LEFT, CMD_WORD_RIGHT: begin
              if (hs) begin
                cur <= (cmd_q == CMD_WORD_LEFT) ? lo : hi;
                anc <= (cmd_q == CMD_WORD_LEFT) ? lo : hi;
                sel <= 1'b0;
              end else begin
                p          <= cur;
                scan_phase <= 2'd0;
                scan_right <= (cmd_q == CMD_WORD_RIGHT);
                state      <= ST_SCAN;
              end
            end
            CMD_HOME: begin
              cur <= '0;
              anc <= '0;
              sel <= 1'b0;
            end
            CMD_END: begin
              cur <= len;
              anc <= len;
              sel <= 1'b0;
            end
            CMD_SEL_LEFT, CMD_SEL_RIGHT, CMD_SEL_WLEFT, CMD_SEL_WRIGHT,
            CMD_SEL_HOME, CMD_SEL_END: begin
              if (!sel) begin
                anc <= cur;
                sel <= 1'b1;
              end
              if (cmd_q == CMD_SEL_LEFT) begin
                cur <= step_l;
              end else if (cmd_q == CMD_SEL_RIGHT) begin
                cur <= step_r;
              end else if (cmd_q == CMD_SEL_HOME) begin
                cur <= '0;
              end else if (cmd_q == CMD_SEL_END) begin
                cur <= len;
              end else begin
                p          <= cur;
                scan_phase <= 2'd0;
                scan_right <= (cmd_q == CMD_SEL_WRIGHT);
                state      <= ST_SCAN;
              end
            end
            CMD_DEL_LEFT, CMD_DEL_RIGHT, CMD_DEL_WORD: begin
              if (hs) begin
                cut_lo  <= lo;
                cut_cnt <= hi - lo;
                state   <= ST_CUT;
              end else if (cmd_q == CMD_DEL_LEFT) begin
                if (cur != '0) begin
                  cut_lo  <= cur - PW'(1);
                  cut_cnt <= PW'(1);
                  state   <= ST_CUT;
                end
              end else if (cmd_q == CMD_DEL_RIGHT) begin
                if (cur < len) begin
                  cut_lo  <= cur;
                  cut_cnt <= PW'(1);
                  state   <= ST_CUT;
                end
              end else begin
                p          <= cur;
                scan_phase <= 2'd0;
                scan_right <= 1'b0;
                state      <= ST_SCAN;
              end
            end
            CMD_PREV, CMD_NEXT: begin
              if (hen && (cmd_q == CMD_PREV ? (count != '0) : browsing)) begin
                if (cmd_q == CMD_NEXT && !next_ok) begin
                  browsing <= 1'b0;
                  len      <= '0;
                  cur      <= '0;
                  anc      <= '0;
                  sel      <= 1'b0;
                end else begin
                  browsing <= 1'b1;
                  bidx     <= hist_idx;
                  ld_slot  <= ring_slot;
                  ld_n     <= ld_n_c;
                  rd_idx   <= '0;
                  wr_valid <= 1'b0;
                  state    <= ST_LOAD;
                end
              end
            end
            CMD_INSERT: begin
              if (printable) begin
                if (hs) begin
                  cut_lo  <= lo;
                  cut_cnt <= hi - lo;
                  state   <= ST_CUT;
                end else begin
                  state <= ST_INS;
                end
              end
            end
            CMD_COMMIT: begin
              st_on <= hen && (len != '0);
              if (hen && (len != '0)) begin
                if (int'(count) < HISTORY_ENTRIES) begin
                  count <= count + CW'(1);
                end else begin
                  oldest <= oldest_inc;
                end
                entry_len[ring_slot] <= st_n_c;
                st_slot <= ring_slot;
                st_n    <= st_n_c;
              end
              if (hen) begin
                browsing <= 1'b0;
              end
              em_n <= len;
              em_i <= '0;
              len  <= '0;
              cur  <= '0;
              anc  <= '0;
              sel  <= 1'b0;
              if (len != '0) begin
                state <= ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          if (scan_right) begin
            case (scan_phase)
              2'd0: begin
                scan_cls   <= avail && c_word;
                scan_phase <= 2'd1;
              end
              2'd1: begin
                if (avail && match) begin
                  p <= p + PW'(1);
                end else begin
                  scan_phase <= 2'd2;
                end
              end
              default: begin
                if (avail && c_blank) begin
                  p <= p + PW'(1);
                end else begin
                  scan_phase <= 2'd3;
                end
              end
            endcase
          end else begin
            case (scan_phase)
              2'd0: begin
                if (avail && c_blank) begin
                  p <= p - PW'(1);
                end else if (avail) begin
                  scan_cls   <= c_word;
                  scan_phase <= 2'd1;
                end else begin
                  scan_phase <= 2'd3;
                end
              end
              2'd1: begin
                if (avail && match) begin
                  p <= p - PW'(1);
                end else begin
                  scan_phase <= 2'd3;
                end
              end
              default: begin
                scan_phase <= 2'd3;
              end
            endcase
          end
          // scan finished: p holds the word boundary
          if (scan_phase == 2'd3) begin
            if (cmd_q == CMD_DEL_WORD) begin
              if (p < cur) begin
                cut_lo  <= p;
                cut_cnt <= cur - p;
                state   <= ST_CUT;
              end else begin
                state <= ST_FIN;
              end
            end else begin
              cur <= p;
              if (cmd_q == CMD_WORD_LEFT || cmd_q == CMD_WORD_RIGHT) begin
                anc <= p;
                sel <= 1'b0;
              end
              state <= ST_FIN;
            end
          end
        end
        ST_CUT: begin
          if (cut_cnt != '0) begin
            cut_cnt <= cut_cnt - PW'(1);
            len     <= len - PW'(1);
          end else begin
            cur   <= cut_lo;
            anc   <= cut_lo;
            sel   <= 1'b0;
            state <= (cmd_q == CMD_INSERT) ? ST_INS : ST_FIN;
          end
        end
        ST_INS: begin
          if (int'(len) < LINE_CAPACITY - 1) begin
            cur <= cur + PW'(1);
            len <= len + PW'(1);
          end
          state <= ST_FIN;
        end
        ST_LOAD: begin
          // read one byte a cycle, written into its cell in the cycle after its read
          if (rd_idx != ld_n) begin
            rd_idx   <= rd_idx + PW'(1);
            wr_valid <= 1'b1;
            wr_idx   <= rd_idx;
          end else begin
            wr_valid <= 1'b0;
            if (!wr_valid) begin
              len   <= ld_n;
              cur   <= ld_n;
              anc   <= ld_n;
              sel   <= 1'b0;
              state <= ST_FIN;
            end
          end
        end
        ST_EMIT: begin
          result.is_line_byte <= 1'b1;
          result.line_byte    <= cell_data[0];
          result.last         <= em_last;
          result.line_length  <= 6'(len);
          result.cursor_pos   <= 6'(cur);
          result.select_on    <= sel;
          result.anchor_pos   <= 6'(anc);
          strobe              <= 1'b1;
          em_i                <= em_i + PW'(1);
          if (em_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          result.is_line_byte <= 1'b0;
          result.line_byte    <= 8'h00;
          result.last         <= 1'b1;
          result.line_length  <= 6'(len);
          result.cursor_pos   <= 6'(cur);
          result.select_on    <= sel;
          result.anchor_pos   <= 6'(anc);
          strobe              <= 1'b1;
          state               <= ST_IDLE;
        end
      endcase
    end
  end

  // a cut shortens the line before the cursor moves, so check between items
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cur <= len) else $error("cursor beyond end of line");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    int'(len) <= LINE_CAPACITY - 1) else $error("line longer than capacity");

  a_line_byte_src: assert property (@(posedge clk) disable iff (rst)
    strobe && result.is_line_byte |-> $past(state) == ST_EMIT)
    else $error("line byte outside commit");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == ST_EXEC) else $error("item not taken");

endmodule

### bench/line_editor_with_history_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_editor_with_history_unit_tb
// Drives edit, history and commit commands through the line editor and
// compares every result against a behavioural model of the editor state,
// the history ring and the committed line bytes.
// ----------------------------------------------------------------------------
module line_editor_with_history_unit_tb;
  import leh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  command_t command;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;
  logic     strobe;
  result_t  result;

  line_editor_with_history_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // model state
  logic [7:0] ed_line [LINE_CAPACITY];
  int         ed_len, ed_cur, ed_anchor;
  bit         ed_sel;
  logic [7:0] ring_data [HISTORY_ENTRIES][HIST_ENTRY_BYTES];
  int         ring_len [HISTORY_ENTRIES];
  int         ring_oldest, ring_count, browse_pos;
  bit         browsing, hist_en;

  command_t   cmd_queue [$];
  result_t    expected_results [$];
  int         errors, mismatches, items_sent, results_seen, commits_seen;
  int         idle_cycles;
  bit         cfg_busy;
  logic       cfg_value;

  function automatic bit word_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit blank_byte(logic [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  function automatic int word_start(int p);
    while (p > 0 && blank_byte(ed_line[p-1])) p--;
    if (p > 0 && word_byte(ed_line[p-1]))
      while (p > 0 && word_byte(ed_line[p-1])) p--;
    else
      while (p > 0 && !blank_byte(ed_line[p-1]) && !word_byte(ed_line[p-1])) p--;
    return p;
  endfunction

  function automatic int word_end(int p);
    if (p < ed_len && word_byte(ed_line[p]))
      while (p < ed_len && word_byte(ed_line[p])) p++;
    else
      while (p < ed_len && !blank_byte(ed_line[p]) && !word_byte(ed_line[p])) p++;
    while (p < ed_len && blank_byte(ed_line[p])) p++;
    return p;
  endfunction

  function automatic bit has_selection();
    return ed_sel && ed_anchor != ed_cur;
  endfunction

  function automatic int sel_low();
    return ed_anchor < ed_cur ? ed_anchor : ed_cur;
  endfunction

  function automatic int sel_high();
    return ed_anchor > ed_cur ? ed_anchor : ed_cur;
  endfunction

  function automatic void clear_sel();
    ed_anchor = ed_cur;
    ed_sel    = 1'b0;
  endfunction

  function automatic void open_sel();
    if (!ed_sel) begin
      ed_anchor = ed_cur;
      ed_sel    = 1'b1;
    end
  endfunction

  function automatic void remove_range(int lo, int hi);
    if (lo >= hi || hi > ed_len) return;
    for (int i = lo; i < ed_len - (hi - lo); i++) ed_line[i] = ed_line[i + hi - lo];
    ed_len -= hi - lo;
    ed_cur = lo;
    clear_sel();
  endfunction

  function automatic bit remove_selection();
    if (!has_selection()) return 1'b0;
    remove_range(sel_low(), sel_high());
    return 1'b1;
  endfunction

  function automatic void recall_entry(int idx);
    int slot, n;
    if (idx >= ring_count) return;
    slot = (ring_oldest + idx) % HISTORY_ENTRIES;
    n = ring_len[slot];
    if (n > LINE_CAPACITY - 1) n = LINE_CAPACITY - 1;
    for (int i = 0; i < n; i++) ed_line[i] = ring_data[slot][i];
    ed_len = n;
    ed_cur = n;
    clear_sel();
  endfunction

  function automatic result_t status_result(bit is_b, logic [7:0] b, bit fin);
    result_t r;
    r.is_line_byte = is_b;
    r.line_byte    = b;
    r.last         = fin;
    r.line_length  = ed_len[5:0];
    r.cursor_pos   = ed_cur[5:0];
    r.select_on    = ed_sel;
    r.anchor_pos   = ed_anchor[5:0];
    return r;
  endfunction

  // apply one command to the model and queue the results it should produce
  function automatic void predict_editor(command_t c);
    int n, slot;
    logic [7:0] committed [LINE_CAPACITY];
    case (c.cmd)
      CMD_LEFT: begin
        if (has_selection()) ed_cur = sel_low(); else if (ed_cur > 0) ed_cur--;
        clear_sel();
      end
      CMD_RIGHT: begin
        if (has_selection()) ed_cur = sel_high(); else if (ed_cur < ed_len) ed_cur++;
        clear_sel();
      end
      CMD_WORD_LEFT: begin
        ed_cur = has_selection() ? sel_low() : word_start(ed_cur);
        clear_sel();
      end
      CMD_WORD_RIGHT: begin
        ed_cur = has_selection() ? sel_high() : word_end(ed_cur);
        clear_sel();
      end
      CMD_HOME: begin ed_cur = 0; clear_sel(); end
      CMD_END: begin ed_cur = ed_len; clear_sel(); end
      CMD_SEL_LEFT: begin open_sel(); if (ed_cur > 0) ed_cur--; end
      CMD_SEL_RIGHT: begin open_sel(); if (ed_cur < ed_len) ed_cur++; end
      CMD_SEL_WLEFT: begin open_sel(); ed_cur = word_start(ed_cur); end
      CMD_SEL_WRIGHT: begin open_sel(); ed_cur = word_end(ed_cur); end
      CMD_SEL_HOME: begin open_sel(); ed_cur = 0; end
      CMD_SEL_END: begin open_sel(); ed_cur = ed_len; end
      CMD_DEL_LEFT: begin
        if (!remove_selection() && ed_cur > 0) remove_range(ed_cur - 1, ed_cur);
      end
      CMD_DEL_RIGHT: begin
        if (!remove_selection() && ed_cur < ed_len) remove_range(ed_cur, ed_cur + 1);
      end
      CMD_DEL_WORD: begin
        if (!remove_selection()) remove_range(word_start(ed_cur), ed_cur);
      end
      CMD_PREV: begin
        if (hist_en && ring_count != 0) begin
          if (!browsing) begin
            browsing   = 1'b1;
            browse_pos = ring_count - 1;
          end else if (browse_pos > 0) begin
            browse_pos--;
          end
          recall_entry(browse_pos);
        end
      end
      CMD_NEXT: begin
        if (hist_en && browsing) begin
          if (browse_pos + 1 < ring_count) begin
            browse_pos++;
            recall_entry(browse_pos);
          end else begin
            browsing = 1'b0;
            ed_len   = 0;
            ed_cur   = 0;
            clear_sel();
          end
        end
      end
      CMD_INSERT: begin
        if (c.char_byte >= 8'h20 && c.char_byte != 8'h7f) begin
          void'(remove_selection());
          if (ed_len + 1 < LINE_CAPACITY) begin
            for (int i = ed_len; i > ed_cur; i--) ed_line[i] = ed_line[i-1];
            ed_line[ed_cur] = c.char_byte;
            ed_cur++;
            ed_len++;
          end
        end
      end
      CMD_COMMIT: begin
        if (hist_en && ed_len != 0) begin
          if (ring_count < HISTORY_ENTRIES) begin
            slot = (ring_oldest + ring_count) % HISTORY_ENTRIES;
            ring_count++;
          end else begin
            slot = ring_oldest;
            ring_oldest = (ring_oldest + 1) % HISTORY_ENTRIES;
          end
          n = ed_len > HIST_ENTRY_BYTES - 1 ? HIST_ENTRY_BYTES - 1 : ed_len;
          for (int i = 0; i < n; i++) ring_data[slot][i] = ed_line[i];
          ring_len[slot] = n;
        end
        n = ed_len;
        for (int i = 0; i < n; i++) committed[i] = ed_line[i];
        ed_len = 0;
        ed_cur = 0;
        clear_sel();
        if (hist_en) browsing = 1'b0;
        if (n != 0) begin
          for (int i = 0; i < n; i++)
            expected_results.push_back(status_result(1'b1, committed[i], i + 1 == n));
          return;
        end
      end
      default: ;
    endcase
    expected_results.push_back(status_result(1'b0, 8'h00, 1'b1));
  endfunction

  // driver: bursts of commands with random gaps
  int burst_left, gap_left;
  bit taken;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (taken) begin
      // item was taken at the last rising edge
      start <= 1'b0;
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0 && !cfg_busy) begin
        command <= cmd_queue[0];
        start   <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      predict_editor(command);
      void'(cmd_queue.pop_front());
      items_sent++;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 12);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (strobe || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (strobe) begin
        results_seen++;
        if (result.is_line_byte && result.last) commits_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result %p", result);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result !== exp_r) begin
            errors++;
            if (mismatches < 10) $display("mismatch: expected %p, got %p", exp_r, result);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // configuration channel
  always @(negedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
    end else if (cfg_busy && !cfg_valid) begin
      cfg_data  <= cfg_value;
      cfg_valid <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      hist_en  = cfg_data;
      cfg_busy <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || start || expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_history(bit en);
    wait_drained();
    cfg_value = en;
    cfg_busy  = 1'b1;
    while (cfg_busy) @(posedge clk);
  endtask

  function automatic void push_cmd(logic [4:0] op, logic [7:0] b = 8'h00);
    command_t c;
    c.cmd       = op;
    c.char_byte = b;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return "_";
      2: return 8'($urandom_range("a", "z"));
      3: return 8'($urandom_range("0", "9"));
      4: return 8'($urandom_range(8'h21, 8'h2f));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // a typed-in word sequence with edits, sometimes committed
  function automatic void push_session();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) push_cmd(CMD_INSERT, text_byte());
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) push_cmd(CMD_INSERT, text_byte());
      else push_cmd(5'($urandom_range(CMD_LEFT, CMD_NEXT)), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) != 0) push_cmd(CMD_COMMIT);
  endfunction

  function automatic void push_noise();
    push_cmd(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endfunction

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    command    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    cfg_busy   = 1'b0;
    cfg_value  = 1'b0;
    ed_len = 0; ed_cur = 0; ed_anchor = 0; ed_sel = 0;
    ring_oldest = 0; ring_count = 0; browse_pos = 0; browsing = 0; hist_en = 1;
    errors = 0; mismatches = 0; items_sent = 0; results_seen = 0; commits_seen = 0;
    burst_left = 0; gap_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty commit, history on empty ring, word scans, selection edits
    push_cmd(CMD_COMMIT);
    push_cmd(CMD_PREV);
    push_cmd(CMD_NEXT);
    push_cmd(CMD_INSERT, 8'h1f);
    push_cmd(CMD_INSERT, 8'h7f);
    push_cmd(CMD_INSERT, 8'hff);
    push_cmd(CMD_INSERT, "a");
    push_cmd(CMD_INSERT, " ");
    push_cmd(CMD_INSERT, 8'h20);
    push_cmd(CMD_INSERT, "_");
    push_cmd(CMD_INSERT, ",");
    push_cmd(CMD_WORD_LEFT);
    push_cmd(CMD_SEL_WLEFT);
    push_cmd(CMD_SEL_RIGHT);
    push_cmd(CMD_DEL_LEFT);
    push_cmd(CMD_SEL_HOME);
    push_cmd(CMD_INSERT, "Z");
    push_cmd(CMD_WORD_RIGHT);
    push_cmd(CMD_SEL_WRIGHT);
    push_cmd(CMD_SEL_END);
    push_cmd(CMD_DEL_WORD);
    push_cmd(5'd31);
    push_cmd(CMD_COMMIT);
    push_cmd(CMD_PREV);
    push_cmd(CMD_DEL_RIGHT);
    set_history(1'b1);

    // fill the line past capacity with an active selection, then commit
    for (int i = 0; i < 66; i++) push_cmd(CMD_INSERT, (i % 7 == 0) ? 8'h09 + 8'h17 : "x");
    push_cmd(CMD_SEL_LEFT);
    push_cmd(CMD_INSERT, "q");
    push_cmd(CMD_COMMIT);
    set_history(1'b0);

    while (items_sent + cmd_queue.size() < 160) begin
      if ($urandom_range(0, 4) == 0) push_noise(); else push_session();
    end
    set_history(1'b1);
    while (items_sent + cmd_queue.size() < 310) begin
      if ($urandom_range(0, 4) == 0) push_noise(); else push_session();
    end
    wait_drained();

    $display("%0d commands, %0d results, %0d non-empty commits, history ring held %0d",
             items_sent, results_seen, commits_seen, ring_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
